// File: rtl/core/bwbq_pkg.sv
// Shared constants, payload types and the sine table builder for the stereo biquad.
`default_nettype none

package bwbq_pkg;

    localparam int SAMPLE_WIDTH     = 24;
    localparam int SINE_DEPTH       = 1024;
    localparam int SINE_ABITS       = $clog2(SINE_DEPTH);
    localparam int COEF_FRAC_BITS   = 28;

    localparam longint ONE_Q30       = 64'sd1073741824;
    localparam longint HALF_PI_Q30   = 64'sd1686629713;
    localparam longint INV_SQRT2_Q30 = 64'sd759250125;
    localparam logic [31:0] PHASE_049 = 32'd2104533975;

    localparam logic [16:0] FC_MIN = 17'd5;
    localparam logic [17:0] FS_MIN = 18'd8000;
    localparam logic [17:0] FS_MAX = 18'd192000;

    localparam logic        MODE_RESET   = 1'b0;
    localparam logic [16:0] CUTOFF_RESET = 17'd1000;
    localparam logic [17:0] RATE_RESET   = 18'd48000;

    // register indexes on the APB port
    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_CUTOFF = 2'd1,
        REG_RATE   = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_in;
        logic signed [SAMPLE_WIDTH-1:0] right_in;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
    } out_t;

    typedef logic signed [31:0] sine_rom_t [SINE_DEPTH];

    // series term divide by (2k)(2k+1), k = 1..8
    function automatic longint unsigned series_step(longint unsigned y, int k);
        case (k)
            8:       return y / 64'd272;
            7:       return y / 64'd210;
            6:       return y / 64'd156;
            5:       return y / 64'd110;
            4:       return y / 64'd72;
            3:       return y / 64'd42;
            2:       return y / 64'd20;
            default: return y / 64'd6;
        endcase
    endfunction

    // sin over a quarter turn in Q1.30, Taylor series in Horner form
    function automatic longint unsigned quarter_sin(longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (r * longint'(HALF_PI_Q30)) >> 30;
        x2 = (x * x) >> 30;
        t  = longint'(ONE_Q30);
        for (int k = 8; k >= 1; k--) begin
            t = longint'(ONE_Q30) - series_step((x2 * t) >> 30, k);
        end
        s = (x * t) >> 30;
        if (s > longint'(ONE_Q30)) s = longint'(ONE_Q30);
        return s;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned ph;
        longint unsigned q;
        longint unsigned r;
        longint unsigned v;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            ph = longint'(k) << (32 - SINE_ABITS);
            q  = (ph >> 30) & 64'd3;
            r  = ph & (longint'(ONE_Q30) - 64'd1);
            if (q[0]) r = longint'(ONE_Q30) - r;
            v = quarter_sin(r);
            if (q >= 64'd2) rom[k] = 32'(-$signed(v));
            else rom[k] = 32'(v);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/butterworth_biquad_stereo_top.sv
// Stereo Butterworth biquad (lowpass/highpass) with on-chip coefficient generation.
//
// Input channel s_valid/s_ready/s_data carries one left/right Q1.23 pair per transfer;
// the result channel m_valid/m_ready/m_data returns one saturated filtered pair each.
// One shared 33x33 multiplier and one radix-2 divider run under a sequencer.
// Each pair runs from acceptance to m_valid as two channels of five
// multiply-accumulate steps plus rounding. The block takes one pair at a time;
// s_ready is high only when the sequencer is idle. A finished result sits in the
// output register, so the next pair is accepted while it waits; if the receiver
// stalls longer, the second result holds in the sequencer until the output
// register frees up.
// After reset, and after any write to mode, cutoff or sample rate, the coefficients
// are recomputed: four 64-step divisions plus the phase divide (skipped when the
// cutoff hits the upper clamp) and table lookups, with s_ready low. Reset
// loads mode 0, 1000 Hz, 48000 Hz and clears the filter history; a mode write
// clears the history as well.
// APB registers: 0x0 mode, 0x4 cutoff_hz, 0x8 sample_rate_hz; pready is always high.
`default_nettype none

module butterworth_biquad_stereo_top
    import bwbq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        C_START,
        C_SIN_A,
        C_SIN_B,
        C_SIN_MUL,
        C_SIN_ADD,
        C_ALPHA_MUL,
        C_ALPHA,
        C_DIV_START,
        C_DIV_RUN,
        C_DIV_DONE,
        F_MUL,
        F_ACC,
        F_END,
        F_OUT
    } state_t;

    localparam sine_rom_t SINE_ROM = build_sine_rom();
    localparam int SW = SAMPLE_WIDTH;
    localparam logic signed [65:0] SAT_POS = 66'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] SAT_NEG = -66'sh0_7FFF_FFFF_FFFF_FFFF;

    state_t state_reg;

    logic        mode_reg;
    logic [16:0] cutoff_reg;
    logic [17:0] rate_reg;

    logic [31:0]        phase_reg;
    logic               which_reg;
    logic signed [31:0] a_val_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] alpha_reg;
    logic signed [31:0] rom_q_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] coef_reg [5];

    logic [63:0] div_dq_reg;
    logic [31:0] div_rem_reg;
    logic [31:0] div_den_reg;
    logic [5:0]  div_cnt_reg;
    logic        div_neg_reg;
    logic        div_phase_reg;
    logic [1:0]  div_idx_reg;

    in_t                   in_reg;
    logic                  ch_reg;
    logic [2:0]            k_reg;
    logic signed [63:0]    acc_reg;
    logic signed [SW-1:0]  xh_reg [4];
    logic signed [31:0]    yh_reg [4];
    logic signed [SW-1:0]  res_l_reg;
    logic signed [SW-1:0]  res_r_reg;
    logic                  m_valid_reg;
    out_t                  m_data_reg;

    // APB decode
    logic     wr_en;
    reg_idx_t wr_idx;
    logic     cfg_wr;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr = wr_en && (wr_idx != REG_NONE);

    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_MODE:   prdata = {31'd0, mode_reg};
            REG_CUTOFF: prdata = {15'd0, cutoff_reg};
            REG_RATE:   prdata = {14'd0, rate_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // a register write takes the cycle, so no transfer lands with it
    assign s_ready = (state_reg == S_IDLE) && !cfg_wr;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    logic out_load;
    assign out_load = (state_reg == F_OUT) && !cfg_wr && (!m_valid_reg || m_ready);

    // clamped cutoff and rate
    logic [16:0] fc_c;
    logic [17:0] fs_c;
    logic        fc_over;
    always_comb begin
        fc_c = (cutoff_reg < FC_MIN) ? FC_MIN : cutoff_reg;
        if (rate_reg < FS_MIN) fs_c = FS_MIN;
        else if (rate_reg > FS_MAX) fs_c = FS_MAX;
        else fs_c = rate_reg;
        fc_over = ({8'd0, fc_c} * 25'd100) > ({7'd0, fs_c} * 25'd49);
    end

    // sine table lookup address and interpolation fraction
    logic [31:0]            p_eff;
    logic [SINE_ABITS-1:0]  tab_idx;
    logic [31:0]            tab_frac;
    logic [SINE_ABITS-1:0]  rom_addr;
    assign p_eff    = which_reg ? (phase_reg + 32'h4000_0000) : phase_reg;
    assign tab_idx  = p_eff[31 -: SINE_ABITS];
    assign tab_frac = {p_eff[31-SINE_ABITS:0], {SINE_ABITS{1'b0}}};
    assign rom_addr = (state_reg == C_SIN_B) ? tab_idx + 1'b1 : tab_idx;

    always_ff @(posedge aclk) begin
        rom_q_reg <= SINE_ROM[rom_addr];
    end

    // shared multiplier, product registered every cycle
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_full;
    logic signed [SW-1:0] x_cur;
    logic [1:0]           hbase;
    assign x_cur = ch_reg ? in_reg.right_in : in_reg.left_in;
    assign hbase = {ch_reg, 1'b0};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            C_SIN_MUL: begin
                mul_a = {rom_q_reg[31], rom_q_reg} - {a_val_reg[31], a_val_reg};
                mul_b = {1'b0, tab_frac};
            end
            C_ALPHA_MUL: begin
                mul_a = 33'(sin_reg);
                mul_b = 33'(INV_SQRT2_Q30);
            end
            F_MUL: begin
                mul_a = 33'(coef_reg[k_reg]);
                case (k_reg)
                    3'd0:    mul_b = 33'(x_cur);
                    3'd1:    mul_b = 33'(xh_reg[hbase]);
                    3'd2:    mul_b = 33'(xh_reg[hbase + 2'd1]);
                    3'd3:    mul_b = 33'(yh_reg[hbase]);
                    default: mul_b = 33'(yh_reg[hbase + 2'd1]);
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_full = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_full[63:0];
    end

    // truncating shifts of the product toward zero
    logic signed [63:0] interp_t;
    logic signed [63:0] alpha_t;
    logic signed [31:0] sin_result;
    logic signed [31:0] alpha_result;
    always_comb begin
        interp_t = prod_reg + (prod_reg[63] ? 64'sh0000_0000_FFFF_FFFF : 64'sd0);
        alpha_t  = prod_reg + (prod_reg[63] ? 64'sh0000_0000_3FFF_FFFF : 64'sd0);
        sin_result   = 32'(64'(a_val_reg) + (interp_t >>> 32));
        alpha_result = 32'(alpha_t >>> 30);
    end

    // coefficient numerators and divisors
    logic signed [63:0] a0_full;
    logic [31:0]        a0;
    logic signed [63:0] c64;
    logic signed [63:0] al64;
    logic signed [63:0] onec;
    logic signed [63:0] num;
    logic [63:0]        num_mag;
    logic [31:0]        den;
    always_comb begin
        a0_full = ONE_Q30 + 64'(alpha_reg);
        a0      = (a0_full < 64'sd1) ? 32'd1 : a0_full[31:0];
        c64     = 64'(cos_reg);
        al64    = 64'(alpha_reg);
        onec    = mode_reg ? (ONE_Q30 + c64) : (ONE_Q30 - c64);
        den     = a0;
        case (div_idx_reg)
            2'd0: begin
                num = onec <<< COEF_FRAC_BITS;
                den = {a0[30:0], 1'b0};
            end
            2'd1:    num = mode_reg ? -(onec <<< COEF_FRAC_BITS) : (onec <<< COEF_FRAC_BITS);
            2'd2:    num = -(c64 <<< (COEF_FRAC_BITS + 1));
            default: num = (ONE_Q30 - al64) <<< COEF_FRAC_BITS;
        endcase
        num_mag = num[63] ? 64'(-num) : 64'(num);
    end

    // one restoring divide step
    logic [32:0] rem_sh;
    logic        q_bit;
    logic [31:0] rem_new;
    logic [63:0] q_signed;
    always_comb begin
        rem_sh   = {div_rem_reg, div_dq_reg[63]};
        q_bit    = rem_sh >= {1'b0, div_den_reg};
        rem_new  = q_bit ? 32'(rem_sh - {1'b0, div_den_reg}) : rem_sh[31:0];
        q_signed = div_neg_reg ? -div_dq_reg : div_dq_reg;
    end

    // saturating accumulate and output rounding
    logic signed [64:0] addend;
    logic signed [65:0] sum66;
    logic signed [63:0] acc_new;
    logic [63:0]        acc_mag;
    logic [63:0]        y_mag;
    logic signed [63:0] y_full;
    logic signed [31:0] y32;
    logic signed [SW-1:0] y_out;
    always_comb begin
        addend = (k_reg < 3'd3) ? 65'(prod_reg) : -65'(prod_reg);
        sum66  = 66'(acc_reg) + 66'(addend);
        if (sum66 > SAT_POS) acc_new = SAT_POS[63:0];
        else if (sum66 < SAT_NEG) acc_new = SAT_NEG[63:0];
        else acc_new = sum66[63:0];

        acc_mag = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
        y_mag   = (acc_mag + (64'd1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
        y_full  = acc_reg[63] ? -$signed(y_mag) : $signed(y_mag);
        if (y_full > 64'sh7FFF_FFFF) y32 = 32'sh7FFF_FFFF;
        else if (y_full < -64'sh8000_0000) y32 = -32'sh8000_0000;
        else y32 = y_full[31:0];
        if (y32 > 32'((1 <<< (SW - 1)) - 1)) y_out = {1'b0, {(SW-1){1'b1}}};
        else if (y32 < -32'(1 <<< (SW - 1))) y_out = {1'b1, {(SW-1){1'b0}}};
        else y_out = y32[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= C_START;
            mode_reg      <= MODE_RESET;
            cutoff_reg    <= CUTOFF_RESET;
            rate_reg      <= RATE_RESET;
            m_valid_reg   <= 1'b0;
            which_reg     <= 1'b0;
            ch_reg        <= 1'b0;
            k_reg         <= '0;
            div_cnt_reg   <= '0;
            div_idx_reg   <= '0;
            div_phase_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end else begin
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;

            // register writes restart the coefficient sequence
            if (cfg_wr) begin
                state_reg <= C_START;
                case (wr_idx)
                    REG_MODE: begin
                        mode_reg <= pwdata[0];
                        for (int i = 0; i < 4; i++) begin
                            xh_reg[i] <= '0;
                            yh_reg[i] <= '0;
                        end
                    end
                    REG_CUTOFF: cutoff_reg <= pwdata[16:0];
                    REG_RATE:   rate_reg   <= pwdata[17:0];
                    default:    ;
                endcase
            end else begin
                case (state_reg)
                    S_IDLE: begin
                        if (s_valid) begin
                            in_reg    <= s_data;
                            ch_reg    <= 1'b0;
                            k_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= F_MUL;
                        end
                    end
                    C_START: begin
                        which_reg <= 1'b0;
                        if (fc_over) begin
                            phase_reg <= PHASE_049;
                            state_reg <= C_SIN_A;
                        end else begin
                            div_dq_reg    <= {15'd0, fc_c, 32'd0};
                            div_den_reg   <= {14'd0, fs_c};
                            div_rem_reg   <= '0;
                            div_cnt_reg   <= '0;
                            div_neg_reg   <= 1'b0;
                            div_phase_reg <= 1'b1;
                            state_reg     <= C_DIV_RUN;
                        end
                    end
                    C_SIN_A: state_reg <= C_SIN_B;
                    C_SIN_B: begin
                        a_val_reg <= rom_q_reg;
                        state_reg <= C_SIN_MUL;
                    end
                    C_SIN_MUL: state_reg <= C_SIN_ADD;
                    C_SIN_ADD: begin
                        if (!which_reg) begin
                            sin_reg   <= sin_result;
                            which_reg <= 1'b1;
                            state_reg <= C_SIN_A;
                        end else begin
                            cos_reg   <= sin_result;
                            state_reg <= C_ALPHA_MUL;
                        end
                    end
                    C_ALPHA_MUL: state_reg <= C_ALPHA;
                    C_ALPHA: begin
                        alpha_reg   <= alpha_result;
                        div_idx_reg <= '0;
                        state_reg   <= C_DIV_START;
                    end
                    C_DIV_START: begin
                        div_dq_reg    <= num_mag + {33'd0, den[31:1]};
                        div_den_reg   <= den;
                        div_rem_reg   <= '0;
                        div_cnt_reg   <= '0;
                        div_neg_reg   <= num[63];
                        div_phase_reg <= 1'b0;
                        state_reg     <= C_DIV_RUN;
                    end
                    C_DIV_RUN: begin
                        div_rem_reg <= rem_new;
                        div_dq_reg  <= {div_dq_reg[62:0], q_bit};
                        div_cnt_reg <= div_cnt_reg + 6'd1;
                        if (div_cnt_reg == 6'd63) state_reg <= C_DIV_DONE;
                    end
                    C_DIV_DONE: begin
                        if (div_phase_reg) begin
                            phase_reg <= div_dq_reg[31:0];
                            state_reg <= C_SIN_A;
                        end else begin
                            case (div_idx_reg)
                                2'd0: begin
                                    coef_reg[0] <= q_signed[31:0];
                                    coef_reg[2] <= q_signed[31:0];
                                end
                                2'd1:    coef_reg[1] <= q_signed[31:0];
                                2'd2:    coef_reg[3] <= q_signed[31:0];
                                default: coef_reg[4] <= q_signed[31:0];
                            endcase
                            if (div_idx_reg == 2'd3) begin
                                state_reg <= S_IDLE;
                            end else begin
                                div_idx_reg <= div_idx_reg + 2'd1;
                                state_reg   <= C_DIV_START;
                            end
                        end
                    end
                    F_MUL: state_reg <= F_ACC;
                    F_ACC: begin
                        acc_reg <= acc_new;
                        if (k_reg == 3'd4) begin
                            state_reg <= F_END;
                        end else begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= F_MUL;
                        end
                    end
                    F_END: begin
                        xh_reg[hbase + 2'd1] <= xh_reg[hbase];
                        xh_reg[hbase]        <= x_cur;
                        yh_reg[hbase + 2'd1] <= yh_reg[hbase];
                        yh_reg[hbase]        <= y32;
                        if (!ch_reg) begin
                            res_l_reg <= y_out;
                            ch_reg    <= 1'b1;
                            k_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= F_MUL;
                        end else begin
                            res_r_reg <= y_out;
                            state_reg <= F_OUT;
                        end
                    end
                    F_OUT: begin
                        if (out_load) begin
                            m_data_reg.left_out  <= res_l_reg;
                            m_data_reg.right_out <= res_r_reg;
                            state_reg            <= S_IDLE;
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a pair is in flight");

    a_cfg_recompute: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && wr_idx != REG_NONE) |=> !s_ready)
        else $error("register write did not restart coefficient computation");

    a_div_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_DIV_RUN) |-> (div_den_reg != 32'd0))
        else $error("divide by zero in coefficient sequence");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == F_OUT))
        else $error("result raised outside the output step");
`endif

endmodule

`default_nettype wire
